// ===== rtl/core/vid_pkg.sv =====
// Shared constants and types for the vertex index dedup block.
package vid_pkg;
    localparam int POS_COUNT_DEF   = 4096;
    localparam int EXTRA_COUNT_DEF = 4096;
    localparam int POS_W    = 13;
    localparam int ATTR_W   = 16;
    localparam int PACKED_W = 13;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd2;

    localparam logic CFG_HAS_TEX    = 1'b0;
    localparam logic CFG_HAS_NORMAL = 1'b1;

    // Request handed from the front part to the back part.
    typedef struct packed {
        logic              bad;
        logic [POS_W-1:0]  pos;
        logic [ATTR_W-1:0] tex;
        logic [ATTR_W-1:0] nrm;
    } t_req;

    // Result handed back out.
    typedef struct packed {
        logic [PACKED_W-1:0] packed_index;
        logic                is_new;
        logic [STATUS_W-1:0] status;
    } t_res;
endpackage

// ===== rtl/core/vid_front.sv =====
// Front part: range check of the position and a two-entry request queue.
module vid_front #(
    parameter int POS_COUNT = vid_pkg::POS_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [vid_pkg::POS_W-1:0]  i_pos_index,
    input  logic [vid_pkg::ATTR_W-1:0] i_tex_index,
    input  logic [vid_pkg::ATTR_W-1:0] i_norm_index,
    output logic                       o_req_valid,
    output vid_pkg::t_req              o_req,
    input  logic                       i_req_take
);
    vid_pkg::t_req r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push, pop;
    vid_pkg::t_req req_in;

    // Classify the incoming request
    always_comb begin
        req_in.bad = (i_pos_index == '0) ||
                     ({19'd0, i_pos_index} > 32'(POS_COUNT));
        req_in.pos = i_pos_index - vid_pkg::POS_W'(1);
        req_in.tex = i_tex_index;
        req_in.nrm = i_norm_index;
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign pop         = i_req_take && (r_cnt != 2'd0);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];

    // Store payload
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= req_in;
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== rtl/core/vid_back.sv =====
// Back part: head table, chain walk through entry memory and allocation.
module vid_back #(
    parameter int POS_COUNT   = vid_pkg::POS_COUNT_DEF,
    parameter int EXTRA_COUNT = vid_pkg::EXTRA_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_has_tex,
    input  logic          i_has_normal,
    input  logic          i_req_valid,
    input  vid_pkg::t_req i_req,
    output logic          o_req_take,
    output logic          o_valid,
    output vid_pkg::t_res o_res,
    input  logic          i_stall
);
    localparam int TOTAL = POS_COUNT + EXTRA_COUNT;
    localparam int AW    = $clog2(TOTAL);
    localparam int HW    = (POS_COUNT > 1) ? $clog2(POS_COUNT) : 1;
    localparam int OW    = $clog2(EXTRA_COUNT + 1);
    localparam int DW    = $clog2(TOTAL + 1);
    localparam int PW    = vid_pkg::PACKED_W;
    localparam int EW    = 2 * vid_pkg::ATTR_W + PW + AW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_HEAD  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [EW-1:0] r_mem [TOTAL];
    logic          r_head [POS_COUNT];
    logic [EW-1:0] r_rd;
    logic          r_hrd;

    logic [2:0]    r_state, n_state;
    logic [HW-1:0] r_clr;
    logic [AW-1:0] r_cur;
    logic [OW-1:0] r_used;
    logic [DW-1:0] r_dist;
    vid_pkg::t_req r_req;
    vid_pkg::t_res r_res;
    logic          r_ovalid;

    logic          we, hwe, hval;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata;
    logic [HW-1:0] haddr;

    logic [vid_pkg::ATTR_W-1:0] e_tex, e_nrm;
    logic [PW-1:0]              e_pk;
    logic [AW-1:0]              e_link;
    logic                       e_hl, match, slot_full;
    logic [AW-1:0]              slot;

    logic             r_patch;
    logic [AW-1:0]    r_pa, r_pl;
    logic [EW-AW-2:0] r_pd;

    assign {e_tex, e_nrm, e_pk, e_link, e_hl} = r_rd;
    assign match = (!i_has_tex || e_tex == r_req.tex) &&
                   (!i_has_normal || e_nrm == r_req.nrm);
    assign slot_full = ({{(32-OW){1'b0}}, r_used} >= 32'(EXTRA_COUNT));
    assign slot = AW'(POS_COUNT) + AW'(r_used);

    assign o_valid    = r_ovalid;
    assign o_res      = r_res;
    assign o_req_take = (r_state == S_IDLE) && !r_ovalid && i_req_valid;

    // Memory ports; the tail link patch uses the write port when it is free
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end else if (r_patch) begin
            r_mem[r_pa] <= {r_pd, r_pl, 1'b1};
        end
        r_rd <= r_mem[raddr];
        if (hwe) r_head[haddr] <= hval;
        r_hrd <= r_head[i_req.pos[HW-1:0]];
    end

    // Sequencer control
    always_comb begin
        n_state = r_state;
        we = 1'b0; waddr = r_cur; wdata = '0;
        hwe = 1'b0; haddr = r_clr; hval = 1'b0;
        raddr = r_cur;
        case (r_state)
            S_CLEAR: begin
                hwe = 1'b1;
                if (r_clr == HW'(POS_COUNT - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (o_req_take) n_state = S_HEAD;
            end
            S_HEAD: begin
                haddr = r_req.pos[HW-1:0];
                if (r_req.bad) begin
                    n_state = S_OUT;
                end else if (!r_hrd) begin
                    hwe = 1'b1; hval = 1'b1;
                    we = 1'b1; waddr = r_cur;
                    wdata = {r_req.tex, r_req.nrm, PW'(r_dist), AW'(0), 1'b0};
                    n_state = S_OUT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_CMP;
            S_CMP: begin
                if (match || e_hl) begin
                    n_state = match ? S_OUT : S_READ;
                end else if (slot_full) begin
                    n_state = S_OUT;
                end else begin
                    we = 1'b1; waddr = slot;
                    wdata = {r_req.tex, r_req.nrm, PW'(r_dist), AW'(0), 1'b0};
                    n_state = S_OUT;
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Walk state and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_clr <= '0; r_used <= '0; r_dist <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + HW'(1);
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (o_req_take) begin
                    r_req <= i_req;
                    r_cur <= AW'(i_req.pos);
                end
                S_HEAD: begin
                    if (r_req.bad) begin
                        r_res <= '{packed_index: '0, is_new: 1'b0,
                                   status: vid_pkg::ST_BAD_POS};
                    end else if (!r_hrd) begin
                        r_res <= '{packed_index: PW'(r_dist), is_new: 1'b1,
                                   status: vid_pkg::ST_OK};
                        r_dist <= r_dist + DW'(1);
                    end
                end
                S_CMP: begin
                    if (match) begin
                        r_res <= '{packed_index: e_pk, is_new: 1'b0,
                                   status: vid_pkg::ST_OK};
                    end else if (e_hl) begin
                        r_cur <= e_link;
                    end else if (slot_full) begin
                        r_res <= '{packed_index: '0, is_new: 1'b0,
                                   status: vid_pkg::ST_FULL};
                    end else begin
                        r_res <= '{packed_index: PW'(r_dist), is_new: 1'b1,
                                   status: vid_pkg::ST_OK};
                        r_dist <= r_dist + DW'(1);
                        r_used <= r_used + OW'(1);
                    end
                end
                S_OUT: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    // Capture the tail entry and its new link at allocation for the later link patch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patch <= 1'b0;
        end else begin
            r_patch <= (r_state == S_CMP) && !match && !e_hl && !slot_full;
        end
        r_pa <= r_cur;
        r_pl <= slot;
        r_pd <= {e_tex, e_nrm, e_pk};
    end
endmodule

// ===== rtl/core/vertex_index_dedup.sv =====
// A bad index or first use of a position passes states S_HEAD and S_OUT; each chain entry adds S_READ and S_CMP.
// Throughput: one corner at a time; the chain walk through one entry-memory port sets it.
// A two-entry request queue in front lets a new corner in while one is worked.
// Reset: synchronous active low; a head-table clearing pass follows it,
// during which no corner is processed (configuration writes still taken).
// Top level of the vertex index dedup block.
module vertex_index_dedup #(
    parameter int POS_COUNT   = vid_pkg::POS_COUNT_DEF,
    parameter int EXTRA_COUNT = vid_pkg::EXTRA_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [vid_pkg::POS_W-1:0]    i_pos_index,
    input  logic [vid_pkg::ATTR_W-1:0]   i_tex_index,
    input  logic [vid_pkg::ATTR_W-1:0]   i_norm_index,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [vid_pkg::PACKED_W-1:0] o_packed_index,
    output logic                         o_is_new,
    output logic [vid_pkg::STATUS_W-1:0] o_status,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [31:0]                  i_cfg_data
);
    logic          r_has_tex, r_has_normal;
    logic          req_valid, req_take;
    vid_pkg::t_req req;
    vid_pkg::t_res res;

    assign o_cfg_ready = 1'b1;

    // Write mode registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_tex <= 1'b0; r_has_normal <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == vid_pkg::CFG_HAS_TEX)    r_has_tex    <= i_cfg_data[0];
            if (i_cfg_index == vid_pkg::CFG_HAS_NORMAL) r_has_normal <= i_cfg_data[0];
        end
    end

    vid_front #(.POS_COUNT(POS_COUNT)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_pos_index, .i_tex_index,
        .i_norm_index, .o_req_valid(req_valid), .o_req(req), .i_req_take(req_take)
    );

    vid_back #(.POS_COUNT(POS_COUNT), .EXTRA_COUNT(EXTRA_COUNT)) u_back (
        .i_clk, .i_rst_n, .i_has_tex(r_has_tex), .i_has_normal(r_has_normal),
        .i_req_valid(req_valid), .i_req(req), .o_req_take(req_take),
        .o_valid, .o_res(res), .i_stall
    );

    assign o_packed_index = res.packed_index;
    assign o_is_new       = res.is_new;
    assign o_status       = res.status;
endmodule
